// ===== rtl/mct_pkg.sv =====
// shared types, constants and codes of the match/capture timer
package mct_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int MATCH_WIDTH = 32;
    localparam int NUM_CH      = 4;
    localparam int MODE_WIDTH  = 3;
    localparam int FLAG_WIDTH  = NUM_CH + 1;
    localparam int GAP_WIDTH   = 16;
    localparam int CTRL_WIDTH  = 3;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int CAP_FLAG    = NUM_CH;

    // mode bits of one channel
    localparam int MODE_NOTIFY = 0;
    localparam int MODE_CLEAR  = 1;
    localparam int MODE_STOP   = 2;

    // control bits
    localparam int CTRL_PWM    = 0;
    localparam int CTRL_IRQ_EN = 1;
    localparam int CTRL_CAP_EN = 2;

    localparam logic [MATCH_WIDTH-1:0] MATCH_RESET = 32'h0000_ffff;
    localparam logic [GAP_WIDTH-1:0]   GAP_RESET   = 16'd8;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [MATCH_WIDTH-1:0] t_match;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_EDGE  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_RESET = 3'd5,
        CMD_LOAD  = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MATCH0 = 3'd0,
        CFG_MATCH1 = 3'd1,
        CFG_MATCH2 = 3'd2,
        CFG_MATCH3 = 3'd3,
        CFG_MODES  = 3'd4,
        CFG_CTRL   = 3'd5,
        CFG_GAP    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                  cmd;
        logic [FLAG_WIDTH-1:0] clear_mask;
        logic [31:0]           load_value;
    } t_item;

    typedef struct packed {
        t_match [NUM_CH-1:0]              match;
        logic [NUM_CH*MODE_WIDTH-1:0]     modes;
        logic [CTRL_WIDTH-1:0]            ctrl;
        logic [GAP_WIDTH-1:0]             gap;
    } t_cfg;

    typedef struct packed {
        logic                  is_running;
        logic                  capture_rejected;
        logic                  irq;
        logic                  tx_level;
        logic [31:0]           captured;
        logic [FLAG_WIDTH-1:0] flag_bits;
        logic [31:0]           count;
    } t_result;

endpackage

// ===== rtl/match_capture_timer_unit.sv =====
// top level of the match/capture timer: stream ports, config port, result register
//
// Timer with four match channels and one filtered edge capture, driven by
// command words on the input stream. Every accepted word yields exactly one result
// word. Throughput is one word per clock while the downstream side takes results:
// the timer state is updated (one increment, four parallel 32-bit compares and one
// subtract for the capture gap) as a word moves from the input register into the
// result register, from which its result is offered. While a finished result
// waits for the downstream side, the input register takes one more word and then
// holds s_axis_tready low until the result drains.
// Configuration writes are always accepted (o_cfg_ready is tied high) and must be
// issued only while no word is in flight; index 7 is ignored.
module match_capture_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // clear_mask[4:0], load_value[36:5], zero fill[39:37]
    input  logic [39:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // count[31:0], flag_bits[36:32], captured[68:37], tx_level[69], irq[70],
    // capture_rejected[71], is_running[72], zero fill[79:73]
    output logic [79:0] m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    mct_pkg::t_item   in_item;
    mct_pkg::t_item   held_item;
    mct_pkg::t_cfg    cfg;
    mct_pkg::t_result step_result;
    logic             held_valid;
    logic             step;

    logic             r_out_valid;
    mct_pkg::t_result r_out;

    // unpack the command word
    assign in_item.cmd        = mct_pkg::t_cmd'(s_axis_tuser);
    assign in_item.clear_mask = s_axis_tdata[4:0];
    assign in_item.load_value = s_axis_tdata[36:5];

    assign o_cfg_ready = 1'b1;

    mct_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // a held word steps the timer whenever the result slot is free or draining
    assign step = held_valid && (!r_out_valid || m_axis_tready);

    mct_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (step),
        .o_item  (held_item)
    );

    mct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule

// ===== rtl/mct_cfg.sv =====
// configuration register file of the match/capture timer
module mct_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [mct_pkg::CFG_IDX_WIDTH-1:0] i_index,
    input  logic [31:0]                       i_data,
    output mct_pkg::t_cfg                     o_cfg
);

    mct_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match <= {mct_pkg::NUM_CH{mct_pkg::MATCH_RESET}};
            r_cfg.modes <= '0;
            r_cfg.ctrl  <= '0;
            r_cfg.gap   <= mct_pkg::GAP_RESET;
        end else if (i_wr) begin
            case (mct_pkg::t_cfg_idx'(i_index))
                mct_pkg::CFG_MATCH0: r_cfg.match[0] <= i_data;
                mct_pkg::CFG_MATCH1: r_cfg.match[1] <= i_data;
                mct_pkg::CFG_MATCH2: r_cfg.match[2] <= i_data;
                mct_pkg::CFG_MATCH3: r_cfg.match[3] <= i_data;
                mct_pkg::CFG_MODES: begin
                    r_cfg.modes <= i_data[mct_pkg::NUM_CH*mct_pkg::MODE_WIDTH-1:0];
                end
                mct_pkg::CFG_CTRL:   r_cfg.ctrl <= i_data[mct_pkg::CTRL_WIDTH-1:0];
                mct_pkg::CFG_GAP:    r_cfg.gap  <= i_data[mct_pkg::GAP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/mct_in_reg.sv =====
// input register stage holding one command word
module mct_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mct_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output mct_pkg::t_item o_item
);

    logic           r_valid;
    mct_pkg::t_item r_item;

    // refill in the same cycle the held word moves on
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/mct_core.sv =====
// timer state and the combinational command step
module mct_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mct_pkg::t_item   i_item,
    input  mct_pkg::t_cfg    i_cfg,
    output mct_pkg::t_result o_result
);

    mct_pkg::t_count                  r_counter, n_counter;
    logic                             r_running, n_running;
    logic [mct_pkg::FLAG_WIDTH-1:0]   r_flags, n_flags;
    mct_pkg::t_count                  r_capture, n_capture;
    mct_pkg::t_count                  r_last, n_last;
    logic                             r_seen, n_seen;
    logic                             r_pwm, n_pwm;

    mct_pkg::t_count                  inc;
    mct_pkg::t_count                  diff;
    logic [mct_pkg::NUM_CH-1:0]       hit;
    logic                             clr_cnt;
    logic                             stop_hit;
    logic                             pwm_set;
    logic                             edge_ok;
    logic                             too_close;
    logic                             rejected;
    logic [mct_pkg::MODE_WIDTH-1:0]   mode;

    assign inc  = r_counter + mct_pkg::t_count'(1);
    assign diff = r_counter - r_last;

    // parallel compares against the incremented count
    always_comb begin
        hit      = '0;
        clr_cnt  = 1'b0;
        stop_hit = 1'b0;
        mode     = '0;
        for (int ch = 0; ch < mct_pkg::NUM_CH; ch++) begin
            mode = i_cfg.modes[ch*mct_pkg::MODE_WIDTH +: mct_pkg::MODE_WIDTH];
            hit[ch] = (mode != '0) && (mct_pkg::t_match'(inc) >= i_cfg.match[ch]);
            if (hit[ch] && mode[mct_pkg::MODE_CLEAR]) clr_cnt = 1'b1;
            if (hit[ch] && mode[mct_pkg::MODE_STOP])  stop_hit = 1'b1;
        end
    end

    assign pwm_set = i_cfg.ctrl[mct_pkg::CTRL_PWM] &&
                     (mct_pkg::t_match'(inc) >= i_cfg.match[0]);

    assign edge_ok   = r_running && i_cfg.ctrl[mct_pkg::CTRL_IRQ_EN] &&
                       i_cfg.ctrl[mct_pkg::CTRL_CAP_EN];
    assign too_close = r_seen && (r_counter >= r_last) &&
                       (diff < mct_pkg::t_count'(i_cfg.gap));

    always_comb begin
        n_counter = r_counter;
        n_running = r_running;
        n_flags   = r_flags;
        n_capture = r_capture;
        n_last    = r_last;
        n_seen    = r_seen;
        n_pwm     = r_pwm;
        rejected  = 1'b0;
        case (i_item.cmd)
            mct_pkg::CMD_TICK: begin
                if (r_running) begin
                    n_flags   = r_flags | mct_pkg::FLAG_WIDTH'(hit);
                    n_running = !stop_hit;
                    n_counter = (clr_cnt || stop_hit) ? '0 : inc;
                    if (hit[2])       n_pwm = 1'b0;
                    else if (pwm_set) n_pwm = 1'b1;
                end
            end
            mct_pkg::CMD_EDGE: begin
                if (edge_ok) begin
                    if (too_close) begin
                        rejected = 1'b1;
                    end else begin
                        n_last    = r_counter;
                        n_seen    = 1'b1;
                        n_capture = r_counter;
                        n_flags[mct_pkg::CAP_FLAG] = 1'b1;
                    end
                end
            end
            mct_pkg::CMD_CLEAR: n_flags = r_flags & ~i_item.clear_mask;
            mct_pkg::CMD_START: begin
                n_running = 1'b1;
                n_counter = '0;
            end
            mct_pkg::CMD_STOP: begin
                n_running = 1'b0;
                n_counter = '0;
            end
            mct_pkg::CMD_RESET: begin
                n_counter = '0;
                n_seen    = 1'b0;
                n_last    = '0;
            end
            mct_pkg::CMD_LOAD: n_counter = i_item.load_value[mct_pkg::COUNT_WIDTH-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_running <= 1'b0;
            r_flags   <= '0;
            r_capture <= '0;
            r_last    <= '0;
            r_seen    <= 1'b0;
            r_pwm     <= 1'b0;
        end else if (i_step) begin
            r_counter <= n_counter;
            r_running <= n_running;
            r_flags   <= n_flags;
            r_capture <= n_capture;
            r_last    <= n_last;
            r_seen    <= n_seen;
            r_pwm     <= n_pwm;
        end
    end

    always_comb begin
        o_result.count            = n_running ? 32'(n_counter) : 32'd0;
        o_result.flag_bits        = n_flags;
        o_result.captured         = 32'(n_capture);
        o_result.tx_level         = n_pwm;
        o_result.irq              = i_cfg.ctrl[mct_pkg::CTRL_IRQ_EN] && (n_flags != '0);
        o_result.capture_rejected = rejected;
        o_result.is_running       = n_running;
    end

`ifndef NO_ASSERTIONS
    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == mct_pkg::CMD_STOP) |=> (!r_running && r_counter == '0))
        else $error("stop did not halt the counter");

    a_capture_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == mct_pkg::CMD_EDGE && edge_ok && !too_close)
        |=> (r_flags[mct_pkg::CAP_FLAG] && r_seen && r_capture == r_last))
        else $error("accepted capture did not latch");

    a_reject_keeps_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && rejected) |=> ($stable(r_capture) && $stable(r_flags)))
        else $error("rejected edge changed capture state");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == mct_pkg::CMD_TICK && !r_running)
        |=> ($stable(r_counter) && $stable(r_flags) && $stable(r_pwm)))
        else $error("tick while stopped changed state");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for match_capture_timer_unit: random command streams checked against a timer predictor
module tb;
    import mct_pkg::*;

    // codes that the package leaves out but the 3-bit fields still allow
    localparam logic [2:0]  CMD_UNUSED   = 3'd7;
    localparam logic [2:0]  CFG_NONE     = 3'd7;

    localparam logic [31:0] CNT_MASK     = 32'((64'd1 << COUNT_WIDTH) - 1);
    localparam int          RAND_PHASES  = 9;
    localparam int          PHASE_WORDS  = 150;
    localparam int          STALL_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [FLAG_WIDTH-1:0] clear_mask;
        logic [31:0]           load_value;
    } t_timer_cmd;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    match_capture_timer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // register copies as seen by the predictor
    t_match                       rg_match [NUM_CH] =
        '{MATCH_RESET, MATCH_RESET, MATCH_RESET, MATCH_RESET};
    logic [NUM_CH*MODE_WIDTH-1:0] rg_modes = '0;
    logic [CTRL_WIDTH-1:0]        rg_ctrl  = '0;
    logic [GAP_WIDTH-1:0]         rg_gap   = GAP_RESET;

    // timer state as seen by the predictor
    logic [31:0]           tm_cnt      = '0;
    logic                  tm_run      = 1'b0;
    logic [FLAG_WIDTH-1:0] tm_flags    = '0;
    logic [31:0]           tm_cap      = '0;
    logic [31:0]           tm_last_cap = '0;
    logic                  tm_cap_seen = 1'b0;
    logic                  tm_pwm      = 1'b0;

    t_timer_cmd cmd_words [$];       // words still to be sent
    t_result    exp_results [$];     // predicted result words, oldest first
    t_timer_cmd drv_word;
    t_result    got_word;
    t_result    want_word;

    int   send_idle_pct = 11;
    int   recv_idle_pct = 67;
    int   errors        = 0;
    int   in_words      = 0;
    int   stall_left    = 0;
    int   cycle_cnt     = 0;
    logic in_fire       = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // one command word through the timer, returns the result word it should produce
    function automatic t_result timer_step(input logic [2:0] cmd,
                                           input logic [FLAG_WIDTH-1:0] mask,
                                           input logic [31:0] load);
        t_result               r;
        logic [MODE_WIDTH-1:0] mode;
        logic                  pwm_set;
        logic                  pwm_clr;
        logic                  clr_cnt;
        logic                  rejected;
        rejected = 1'b0;
        case (cmd)
            CMD_TICK: if (tm_run) begin
                tm_cnt  = (tm_cnt + 32'd1) & CNT_MASK;
                pwm_set = rg_ctrl[CTRL_PWM] && tm_cnt >= rg_match[0];
                pwm_clr = 1'b0;
                clr_cnt = 1'b0;
                // all four channels compare against the new count at once
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    mode = rg_modes[MODE_WIDTH*ch +: MODE_WIDTH];
                    if (mode != '0 && tm_cnt >= rg_match[ch]) begin
                        tm_flags[ch] = 1'b1;
                        if (ch == 2)
                            pwm_clr = 1'b1;
                        if (mode[MODE_CLEAR])
                            clr_cnt = 1'b1;
                        if (mode[MODE_STOP])
                            tm_run = 1'b0;
                    end
                end
                // clear point wins over set point
                if (pwm_set)
                    tm_pwm = 1'b1;
                if (pwm_clr)
                    tm_pwm = 1'b0;
                if (clr_cnt || !tm_run)
                    tm_cnt = '0;
            end
            CMD_EDGE: if (tm_run && rg_ctrl[CTRL_IRQ_EN] && rg_ctrl[CTRL_CAP_EN]) begin
                // too close only without a wrap since the last accepted capture
                if (tm_cap_seen && tm_cnt >= tm_last_cap &&
                    (tm_cnt - tm_last_cap) < 32'(rg_gap)) begin
                    rejected = 1'b1;
                end else begin
                    tm_last_cap        = tm_cnt;
                    tm_cap_seen        = 1'b1;
                    tm_cap             = tm_cnt;
                    tm_flags[CAP_FLAG] = 1'b1;
                end
            end
            CMD_CLEAR: tm_flags = tm_flags & ~mask;
            CMD_START: begin
                tm_run = 1'b1;
                tm_cnt = '0;
            end
            CMD_STOP: begin
                tm_run = 1'b0;
                tm_cnt = '0;
            end
            CMD_RESET: begin
                tm_cnt      = '0;
                tm_cap_seen = 1'b0;
                tm_last_cap = '0;
            end
            CMD_LOAD: tm_cnt = load & CNT_MASK;
            default: ;
        endcase
        r.count            = tm_run ? tm_cnt : 32'd0;
        r.flag_bits        = tm_flags;
        r.captured         = tm_cap;
        r.tx_level         = tm_pwm;
        r.irq              = rg_ctrl[CTRL_IRQ_EN] && (tm_flags != '0);
        r.capture_rejected = rejected;
        r.is_running       = tm_run;
        return r;
    endfunction

    function automatic t_match rand_match();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h0000_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom;
            4: return 32'h0000_ffff - $urandom_range(0, 24);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    task automatic add_word(input logic [2:0] cmd, input logic [FLAG_WIDTH-1:0] mask,
                            input logic [31:0] load);
        cmd_words.push_back('{cmd: cmd, clear_mask: mask, load_value: load});
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_MATCH0, CFG_MATCH1, CFG_MATCH2, CFG_MATCH3: rg_match[idx[1:0]] = val;
            CFG_MODES: rg_modes = val[NUM_CH*MODE_WIDTH-1:0];
            CFG_CTRL:  rg_ctrl  = val[CTRL_WIDTH-1:0];
            CFG_GAP:   rg_gap   = val[GAP_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // rewrite every register, unused bits filled with noise, plus the unused index
    task automatic set_regs(input t_match m0, input t_match m1, input t_match m2,
                            input t_match m3, input logic [11:0] modes,
                            input logic [2:0] ctrl, input logic [15:0] gap);
        write_reg(CFG_MATCH0, m0);
        write_reg(CFG_MATCH1, m1);
        write_reg(CFG_MATCH2, m2);
        write_reg(CFG_MATCH3, m3);
        write_reg(CFG_MODES, {20'($urandom), modes});
        write_reg(CFG_CTRL, {29'($urandom), ctrl});
        write_reg(CFG_GAP, {16'($urandom), gap});
        write_reg(CFG_NONE, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every queued word has gone through and its result came back
    task automatic drain();
        while (cmd_words.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // sender: offers the next queued word, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (cmd_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_word = cmd_words.pop_front();
                s_axis_tdata  <= {3'd0, drv_word.load_value, drv_word.clear_mask};
                s_axis_tuser  <= drv_word.cmd;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off while a stall runs
    always @(negedge i_clk)
        m_axis_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);

    // long stalls start at two fixed points of the input stream
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && (in_words == 400 || in_words == 1100))
            stall_left <= STALL_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // monitor: result words are checked first, then new input words are predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got_word = t_result'(m_axis_tdata[72:0]);
                if (exp_results.size() == 0) begin
                    errors++;
                    $error("result word with nothing expected: %0h", m_axis_tdata);
                end else begin
                    want_word = exp_results.pop_front();
                    check_field("count", want_word.count, got_word.count);
                    check_field("flag_bits", 32'(want_word.flag_bits), 32'(got_word.flag_bits));
                    check_field("captured", want_word.captured, got_word.captured);
                    check_field("tx_level", 32'(want_word.tx_level), 32'(got_word.tx_level));
                    check_field("irq", 32'(want_word.irq), 32'(got_word.irq));
                    check_field("capture_rejected", 32'(want_word.capture_rejected),
                                32'(got_word.capture_rejected));
                    check_field("is_running", 32'(want_word.is_running),
                                32'(got_word.is_running));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                exp_results.push_back(timer_step(s_axis_tuser, s_axis_tdata[4:0],
                                                 s_axis_tdata[36:5]));
                in_words <= in_words + 1;
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("match_capture_timer_unit test failed");
        $finish;
    end

    initial begin
        t_timer_cmd  w;
        t_match      m [NUM_CH];
        logic [11:0] md;
        logic [2:0]  ct;
        logic [15:0] gp;
        int          pick;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: nothing armed, edges ignored, counter wraps at the top
        add_word(CMD_START, '0, '0);
        add_word(CMD_TICK, 5'h1f, 32'hffff_ffff);
        add_word(CMD_EDGE, '0, '0);
        add_word(CMD_LOAD, '0, 32'hffff_ffff);
        add_word(CMD_TICK, '0, '0);
        add_word(CMD_UNUSED, 5'h1f, 32'hffff_ffff);
        drain();

        // ch0 sets pwm at 2, ch1 notifies at 4, ch2 clears count and pwm at 5,
        // ch3 would stop but never matches; capture gap of 3
        set_regs(32'd2, 32'd4, 32'd5, 32'hffff_ffff,
                 {3'b100, 3'b011, 3'b001, 3'b001}, 3'b111, 16'd3);
        add_word(CMD_START, '0, '0);
        add_word(CMD_TICK, '0, '0);
        add_word(CMD_TICK, '0, '0);             // ch0 match, pwm high
        add_word(CMD_EDGE, '0, '0);             // first capture at 2
        add_word(CMD_TICK, '0, '0);
        add_word(CMD_EDGE, '0, '0);             // too close, dropped
        add_word(CMD_TICK, '0, '0);             // ch1 match
        add_word(CMD_TICK, '0, '0);             // ch0 and ch2 together, ch2 wins
        add_word(CMD_EDGE, '0, '0);             // count went below last capture
        add_word(CMD_CLEAR, 5'h15, '0);
        add_word(CMD_LOAD, '0, 32'habcd_fff0);
        add_word(CMD_RESET, '0, '0);            // drops capture history
        add_word(CMD_EDGE, '0, '0);
        add_word(CMD_STOP, '0, '0);
        add_word(CMD_TICK, '0, '0);             // stopped, nothing moves
        add_word(CMD_EDGE, '0, '0);             // stopped, edge ignored
        add_word(CMD_LOAD, '0, 32'h0000_1234);  // loaded but shows 0
        add_word(CMD_CLEAR, 5'h1f, '0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            // sender-light first, then receiver-light, then back to back
            case (ph / 3)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            for (int i = 0; i < NUM_CH; i++)
                m[i] = rand_match();
            md = 12'($urandom);
            if ($urandom_range(0, 1) == 1)
                md = md & ~12'h924;             // keep the timer running more often
            ct = 3'($urandom) | 3'b110;
            gp = 16'($urandom_range(0, 24));
            case (ph)
                2: gp = '0;
                4: begin
                    gp   = 16'hffff;
                    md   = 12'hfff;
                    m[0] = 32'hffff_ffff;
                    m[2] = 32'h0000_ffff;
                end
                7: begin
                    md = '0;
                    ct = '0;
                end
                default: ;
            endcase
            set_regs(m[0], m[1], m[2], m[3], md, ct, gp);

            // mostly ticks and edges, with enough starts to keep the timer alive
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.clear_mask = FLAG_WIDTH'($urandom);
                w.load_value = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 52)
                    w.cmd = CMD_TICK;
                else if (pick < 68)
                    w.cmd = CMD_EDGE;
                else if (pick < 74)
                    w.cmd = CMD_CLEAR;
                else if (pick < 80)
                    w.cmd = CMD_START;
                else if (pick < 83)
                    w.cmd = CMD_STOP;
                else if (pick < 87)
                    w.cmd = CMD_RESET;
                else if (pick < 98)
                    w.cmd = CMD_LOAD;
                else
                    w.cmd = CMD_UNUSED;
                // loads land near the wrap point or near the small match values
                if (w.cmd == CMD_LOAD) begin
                    case ($urandom_range(0, 2))
                        0: w.load_value[15:0] = 16'hffff - 16'($urandom_range(0, 24));
                        1: w.load_value[15:0] = 16'($urandom_range(0, 48));
                        default: ;
                    endcase
                end
                cmd_words.push_back(w);
            end
        end

        drain();
        if (errors == 0 && exp_results.size() == 0)
            $display("match_capture_timer_unit test passed");
        else
            $display("match_capture_timer_unit test failed");
        $finish;
    end

endmodule
